// ===== hdl/obrb_pkg.sv =====
// ----------------------------------------------------------------------------
// obrb_pkg
// Shared types and constants for the overwriting byte ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package obrb_pkg;

  localparam int DEPTH_DEF = 1024;

  localparam int BYTE_W   = 8;
  localparam int CAP_W    = 11;
  localparam int OFFSET_W = 10;
  localparam int COUNT_W  = 11;
  localparam int FILL_W   = 11;
  localparam int KIND_W   = 2;

  localparam int S_TDATA_W = 32;
  localparam int S_TUSER_W = KIND_W;
  localparam int M_TDATA_W = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE = 2'd0,
    KIND_PEEK  = 2'd1,
    KIND_ERASE = 2'd2,
    KIND_READ  = 2'd3
  } kind_e;

  // status of one operation, handed from the control stage to the output stage
  typedef struct packed {
    logic              use_byte;
    logic [FILL_W-1:0] fill_count;
    logic [FILL_W-1:0] linear_readable;
    logic              error;
    logic              overwrote;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/obrb_ram.sv =====
// ----------------------------------------------------------------------------
// obrb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module obrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/obrb_ctrl.sv =====
// ----------------------------------------------------------------------------
// obrb_ctrl
// Pointer and fill-count state, operation decode, RAM access and the
// in-flight stage that waits for the RAM read data.
// ----------------------------------------------------------------------------
`default_nettype none

module obrb_ctrl #(
  parameter int DEPTH = obrb_pkg::DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic [obrb_pkg::CAP_W-1:0]    cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [obrb_pkg::KIND_W-1:0]   kind_i,
  input  wire logic [obrb_pkg::BYTE_W-1:0]   write_byte_i,
  input  wire logic [obrb_pkg::OFFSET_W-1:0] peek_offset_i,
  input  wire logic [obrb_pkg::COUNT_W-1:0]  erase_count_i,
  input  wire logic                          take_i,
  output logic                               res_valid_o,
  output obrb_pkg::res_t                     res_o,
  output logic                               ram_we_o,
  output logic [$clog2(DEPTH)-1:0]           ram_waddr_o,
  output logic [obrb_pkg::BYTE_W-1:0]        ram_wdata_o,
  output logic                               ram_re_o,
  output logic [$clog2(DEPTH)-1:0]           ram_raddr_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = ((CNT_W > obrb_pkg::COUNT_W) ? CNT_W : obrb_pkg::COUNT_W) + 1;

  logic [PTR_W-1:0] rp_q, rp_d, wp_q, wp_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, cap_q, cap_d;

  logic             p_valid_q, p_valid_d;
  logic             p_use_q, p_err_q, p_ovw_q;
  logic [PTR_W-1:0] p_rp_q, p_wp_q;
  logic [CNT_W-1:0] p_cnt_q;

  logic             accept, advance;
  logic             use_byte, err, ovw;
  logic [CNT_W-1:0] lin;
  obrb_pkg::kind_e  kind;

  function automatic logic [PTR_W-1:0] adv(
    input logic [PTR_W-1:0] p,
    input logic [SUM_W-1:0] step,
    input logic [CNT_W-1:0] cap
  );
    logic [SUM_W-1:0] s;
    s = SUM_W'(p) + step;
    if (s >= SUM_W'(cap)) begin
      s = s - SUM_W'(cap);
    end
    return PTR_W'(s);
  endfunction

  assign kind       = obrb_pkg::kind_e'(kind_i);
  assign advance    = p_valid_q && take_i;
  assign in_ready_o = !p_valid_q || take_i;
  assign accept     = in_valid_i && in_ready_o;

  assign ram_waddr_o = wp_q;
  assign ram_wdata_o = write_byte_i;
  assign ram_we_o    = accept && (kind == obrb_pkg::KIND_WRITE);
  assign ram_re_o    = accept && use_byte;

  always_comb begin
    rp_d        = rp_q;
    wp_d        = wp_q;
    cnt_d       = cnt_q;
    cap_d       = cap_q;
    use_byte    = 1'b0;
    err         = 1'b0;
    ovw         = 1'b0;
    ram_raddr_o = rp_q;
    priority if (cfg_valid_i) begin
      if (cfg_wdata_i == '0) begin
        cap_d = CNT_W'(1);
      end else if (32'(cfg_wdata_i) > 32'(DEPTH)) begin
        cap_d = CNT_W'(DEPTH);
      end else begin
        cap_d = CNT_W'(cfg_wdata_i);
      end
      rp_d  = '0;
      wp_d  = '0;
      cnt_d = '0;
    end else if (accept) begin
      unique case (kind)
        obrb_pkg::KIND_WRITE: begin
          if (cnt_q >= cap_q) begin
            rp_d = adv(rp_q, SUM_W'(1), cap_q);
            ovw  = 1'b1;
          end else begin
            cnt_d = cnt_q + CNT_W'(1);
          end
          wp_d = adv(wp_q, SUM_W'(1), cap_q);
        end
        obrb_pkg::KIND_PEEK: begin
          if (SUM_W'(peek_offset_i) >= SUM_W'(cnt_q)) begin
            err = 1'b1;
          end else begin
            use_byte    = 1'b1;
            ram_raddr_o = adv(rp_q, SUM_W'(peek_offset_i), cap_q);
          end
        end
        obrb_pkg::KIND_ERASE: begin
          if (SUM_W'(erase_count_i) > SUM_W'(cnt_q)) begin
            err = 1'b1;
          end else begin
            rp_d  = adv(rp_q, SUM_W'(erase_count_i), cap_q);
            cnt_d = cnt_q - CNT_W'(erase_count_i);
          end
        end
        obrb_pkg::KIND_READ: begin
          if (cnt_q == '0) begin
            err = 1'b1;
          end else begin
            use_byte = 1'b1;
            rp_d     = adv(rp_q, SUM_W'(1), cap_q);
            cnt_d    = cnt_q - CNT_W'(1);
          end
        end
        default: begin
          err = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    p_valid_d = p_valid_q;
    if (accept) begin
      p_valid_d = 1'b1;
    end else if (advance) begin
      p_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q      <= '0;
      wp_q      <= '0;
      cnt_q     <= '0;
      cap_q     <= CNT_W'(DEPTH);
      p_valid_q <= 1'b0;
    end else begin
      rp_q      <= rp_d;
      wp_q      <= wp_d;
      cnt_q     <= cnt_d;
      cap_q     <= cap_d;
      p_valid_q <= p_valid_d;
    end
  end

  // snapshot of the state left by the word in flight
  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_use_q <= use_byte;
      p_err_q <= err;
      p_ovw_q <= ovw;
      p_rp_q  <= rp_d;
      p_wp_q  <= wp_d;
      p_cnt_q <= cnt_d;
    end
  end

  always_comb begin
    if (p_rp_q < p_wp_q) begin
      lin = CNT_W'(p_wp_q - p_rp_q);
    end else if (p_cnt_q == '0) begin
      lin = '0;
    end else begin
      lin = cap_q - CNT_W'(p_rp_q);
    end
  end

  assign res_valid_o           = p_valid_q;
  assign res_o.use_byte        = p_use_q;
  assign res_o.fill_count      = obrb_pkg::FILL_W'(p_cnt_q);
  assign res_o.linear_readable = obrb_pkg::FILL_W'(lin);
  assign res_o.error           = p_err_q;
  assign res_o.overwrote       = p_ovw_q;

endmodule

`default_nettype wire

// ===== hdl/obrb_out.sv =====
// ----------------------------------------------------------------------------
// obrb_out
// Output register: merges RAM read data with the operation status and holds
// the result word until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module obrb_out (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           res_valid_i,
  input  obrb_pkg::res_t                      res_i,
  input  wire logic [obrb_pkg::BYTE_W-1:0]    rdata_i,
  output logic                                take_o,
  output logic                                m_valid_o,
  input  wire logic                           m_ready_i,
  output logic [obrb_pkg::M_TDATA_W-1:0]      m_data_o
);

  logic                              valid_q, valid_d;
  logic [obrb_pkg::M_TDATA_W-1:0]    data_q;
  logic [obrb_pkg::BYTE_W-1:0]       rbyte;

  assign take_o = !valid_q || m_ready_i;
  assign rbyte  = res_i.use_byte ? rdata_i : '0;

  always_comb begin
    valid_d = valid_q;
    if (res_valid_i && take_o) begin
      valid_d = 1'b1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && take_o) begin
      data_q <= {res_i.overwrote, res_i.error, res_i.linear_readable,
                 res_i.fill_count, rbyte};
    end
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = data_q;

endmodule

`default_nettype wire

// ===== hdl/overwriting_byte_ring_buffer.sv =====
// ----------------------------------------------------------------------------
// overwriting_byte_ring_buffer
// Byte ring buffer with programmable capacity; a write into a full buffer
// drops the oldest byte. Supports write, peek, erase and read-remove.
//
//   channel   dir  handshake                     words
//   s_axis    in   s_axis_tvalid/s_axis_tready   one operation
//   m_axis    out  m_axis_tvalid/m_axis_tready   one result per operation
//   cfg       in   cfg_valid_i/cfg_ready_o       capacity write (empties)
//
// One word per cycle sustained while the sink keeps taking results; a result
// word passes from the registered RAM read and the in-flight stage, loaded
// when its operation is taken, into the output register. Reset empties
// the buffer at once; the byte RAM is not cleared and is only read where it
// was written. A stalled output holds; input stalls only when both the
// in-flight stage and the output are full and the sink is not ready.
// ----------------------------------------------------------------------------
`default_nettype none

module overwriting_byte_ring_buffer #(
  parameter int DEPTH = obrb_pkg::DEPTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [obrb_pkg::CAP_W-1:0]      cfg_wdata_i,     // capacity
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // write_byte[7:0], peek_offset[17:8], erase_count[28:18], zero[31:29]
  input  wire logic [obrb_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  input  wire logic [obrb_pkg::S_TUSER_W-1:0]  s_axis_tuser,    // kind[1:0]
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // read_byte[7:0], fill_count[18:8], linear_readable[29:19], error[30],
  // overwrote[31]
  output logic [obrb_pkg::M_TDATA_W-1:0]       m_axis_tdata
);

  localparam int PTR_W = $clog2(DEPTH);

  logic                          take, res_valid;
  obrb_pkg::res_t                res;
  logic                          ram_we, ram_re;
  logic [PTR_W-1:0]              ram_waddr, ram_raddr;
  logic [obrb_pkg::BYTE_W-1:0]   ram_wdata, ram_rdata;

  assign cfg_ready_o = 1'b1;

  obrb_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .kind_i        (s_axis_tuser[1:0]),
    .write_byte_i  (s_axis_tdata[7:0]),
    .peek_offset_i (s_axis_tdata[17:8]),
    .erase_count_i (s_axis_tdata[28:18]),
    .take_i        (take),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr)
  );

  obrb_ram #(
    .WIDTH (obrb_pkg::BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  obrb_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .rdata_i     (ram_rdata),
    .take_o      (take),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ===== hdl/obrb_checker.sv =====
// ----------------------------------------------------------------------------
// obrb_checker
// Port-level checks on the result stream of the ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module obrb_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [obrb_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[30] && m_axis_tdata[31]))
    else $error("error and overwrite flagged together");

  a_linear_le_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[29:19] <= m_axis_tdata[18:8])
    else $error("linear run exceeds fill count");

  a_ovw_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[31] |->
      m_axis_tdata[7:0] == '0 && m_axis_tdata[18:8] != '0)
    else $error("overwrite result with read byte or empty buffer");

endmodule

bind overwriting_byte_ring_buffer obrb_checker u_obrb_checker (.*);

`default_nettype wire

// ===== verif/overwriting_byte_ring_buffer_checker.sv =====
// ----------------------------------------------------------------------------
// overwriting_byte_ring_buffer_checker
// Watches the capacity, operation and result channels of the ring buffer,
// keeps a shadow ring (storage, pointers, fill) to predict the status word
// of every accepted operation, and compares each result word field by field
// with the oldest prediction. Mismatches are counted and handed to the top.
// ----------------------------------------------------------------------------
module overwriting_byte_ring_buffer_checker
  import obrb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  input  wire logic                  cfg_ready_o,
  input  wire logic [CAP_W-1:0]      cfg_wdata_i,
  input  wire logic                  s_axis_tvalid,
  input  wire logic                  s_axis_tready,
  input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
  input  wire logic [S_TUSER_W-1:0]  s_axis_tuser,
  input  wire logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  input  wire logic [M_TDATA_W-1:0]  m_axis_tdata,
  output int                         pending_o,
  output int                         fail_count_o
);

  // first field in the highest bits
  typedef struct packed {
    logic              overwrote;
    logic              error;
    logic [FILL_W-1:0] linear_readable;
    logic [FILL_W-1:0] fill_count;
    logic [BYTE_W-1:0] read_byte;
  } ring_status_t;

  logic [BYTE_W-1:0] ring_mem [DEPTH];
  int unsigned       cap_r;
  int unsigned       rd_ptr;
  int unsigned       wr_ptr;
  int unsigned       fill_r;
  ring_status_t      expected_status_q [$];

  function automatic int unsigned wrap_add(int unsigned ptr, int unsigned step);
    int unsigned sum;
    sum = ptr + step;
    if (sum >= cap_r) sum -= cap_r;
    return sum;
  endfunction

  function automatic ring_status_t predict_op(kind_e kind, logic [BYTE_W-1:0] wbyte,
                                               logic [OFFSET_W-1:0] offset,
                                               logic [COUNT_W-1:0] count);
    ring_status_t st;
    st = '0;
    case (kind)
      KIND_WRITE: begin
        if (fill_r >= cap_r) begin
          rd_ptr = wrap_add(rd_ptr, 1);
          fill_r--;
          st.overwrote = 1'b1;
        end
        ring_mem[wr_ptr] = wbyte;
        wr_ptr = wrap_add(wr_ptr, 1);
        fill_r++;
      end
      KIND_PEEK: begin
        if (offset >= fill_r) st.error = 1'b1;
        else st.read_byte = ring_mem[wrap_add(rd_ptr, offset)];
      end
      KIND_ERASE: begin
        if (count > fill_r) begin
          st.error = 1'b1;
        end else begin
          rd_ptr = wrap_add(rd_ptr, count);
          fill_r -= count;
        end
      end
      default: begin
        if (fill_r == 0) begin
          st.error = 1'b1;
        end else begin
          st.read_byte = ring_mem[rd_ptr];
          rd_ptr = wrap_add(rd_ptr, 1);
          fill_r--;
        end
      end
    endcase
    st.fill_count = FILL_W'(fill_r);
    if (rd_ptr < wr_ptr) st.linear_readable = FILL_W'(wr_ptr - rd_ptr);
    else if (fill_r == 0) st.linear_readable = '0;
    else st.linear_readable = FILL_W'(cap_r - rd_ptr);
    return st;
  endfunction

  task automatic report_error(string what, int got, int want);
    $display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  task automatic check_result(ring_status_t got);
    ring_status_t want;
    if (expected_status_q.size() == 0) begin
      report_error("unexpected result word, tdata", int'(got), 0);
    end else begin
      want = expected_status_q.pop_front();
      if (got.read_byte != want.read_byte)
        report_error("read_byte", got.read_byte, want.read_byte);
      if (got.fill_count != want.fill_count)
        report_error("fill_count", got.fill_count, want.fill_count);
      if (got.linear_readable != want.linear_readable)
        report_error("linear_readable", got.linear_readable, want.linear_readable);
      if (got.error != want.error)
        report_error("error", got.error, want.error);
      if (got.overwrote != want.overwrote)
        report_error("overwrote", got.overwrote, want.overwrote);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_r  = DEPTH;
      rd_ptr = 0;
      wr_ptr = 0;
      fill_r = 0;
      expected_status_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_wdata_i == '0) cap_r = 1;
        else if (int'(cfg_wdata_i) > DEPTH) cap_r = DEPTH;
        else cap_r = int'(cfg_wdata_i);
        rd_ptr = 0;
        wr_ptr = 0;
        fill_r = 0;
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_status_q.push_back(predict_op(kind_e'(s_axis_tuser),
                                               s_axis_tdata[7:0],
                                               s_axis_tdata[17:8],
                                               s_axis_tdata[28:18]));
      if (m_axis_tvalid && m_axis_tready)
        check_result(ring_status_t'(m_axis_tdata));
      pending_o <= expected_status_q.size();
    end
  end

endmodule

// ===== verif/overwriting_byte_ring_buffer_tb.sv =====
// ----------------------------------------------------------------------------
// overwriting_byte_ring_buffer_tb
// Drives operations and capacity writes into the ring buffer: a directed
// run over empty/full/error corners and capacity extremes, then random
// operation mixes and write/read-back packets over several capacities and
// idle patterns, including a burst of writes under a long output stall.
// Checking is done by the attached checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module overwriting_byte_ring_buffer_tb;
  import obrb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 120;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CAP_W-1:0]     cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [S_TUSER_W-1:0] s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  int          pending;
  int          fail_count;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned cap_eff     = DEPTH_DEF;
  bit          hold_go     = 1'b0;
  bit          hold_done   = 1'b0;
  int unsigned hold_left   = 0;
  int unsigned cycle_cnt   = 0;

  overwriting_byte_ring_buffer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  overwriting_byte_ring_buffer_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pending_o     (pending),
    .fail_count_o  (fail_count)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  // receiver: random backpressure, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_go && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // leaves tvalid high after the word is taken; the next call or the
  // caller drops it in the same step
  task automatic send_op(kind_e kind, logic [BYTE_W-1:0] wbyte,
                         logic [OFFSET_W-1:0] offset, logic [COUNT_W-1:0] count);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, count, offset, wbyte};
    s_axis_tuser  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (value == '0) cap_eff = 1;
    else if (int'(value) > DEPTH_DEF) cap_eff = DEPTH_DEF;
    else cap_eff = int'(value);
  endtask

  task automatic run_random(int unsigned n);
    int unsigned         done_n;
    int unsigned         burst;
    int unsigned         sel;
    int unsigned         span;
    kind_e               kind;
    logic [OFFSET_W-1:0] offset;
    logic [COUNT_W-1:0]  count;
    done_n = 0;
    while (done_n < n) begin
      sel = $urandom_range(99);
      if (sel < 12) begin
        // packet: a run of writes, then read back
        span  = (cap_eff + 2 < 24) ? cap_eff + 2 : 24;
        burst = $urandom_range(span, 1);
        repeat (burst)
          send_op(KIND_WRITE, BYTE_W'($urandom_range(255)),
                  OFFSET_W'($urandom_range(1023)), COUNT_W'($urandom_range(1024)));
        repeat (burst)
          send_op(KIND_READ, BYTE_W'($urandom_range(255)),
                  OFFSET_W'($urandom_range(1023)), COUNT_W'($urandom_range(1024)));
        done_n += 2 * burst;
      end else begin
        if (sel < 50) kind = KIND_WRITE;
        else if (sel < 68) kind = KIND_PEEK;
        else if (sel < 80) kind = KIND_ERASE;
        else kind = KIND_READ;
        if ($urandom_range(9) < 7)
          offset = OFFSET_W'($urandom_range((cap_eff < 1024) ? cap_eff : 1023));
        else
          offset = OFFSET_W'($urandom_range(1023));
        sel = $urandom_range(9);
        if (sel < 5) count = COUNT_W'($urandom_range(3));
        else if (sel < 8) count = COUNT_W'($urandom_range(cap_eff + 1));
        else count = COUNT_W'($urandom_range(1024));
        send_op(kind, BYTE_W'($urandom_range(255)), offset, count);
        done_n++;
      end
    end
  endtask

  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("overwriting_byte_ring_buffer test failed");
    $finish;
  end

  initial begin : stimulus
    tx_idle_pct = 32;
    rx_idle_pct <= 69;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty buffer corners at reset capacity
    send_op(KIND_READ,  8'h00, 10'd0,    11'd0);
    send_op(KIND_PEEK,  8'hFF, 10'd0,    11'd0);
    send_op(KIND_ERASE, 8'h00, 10'd0,    11'd0);
    send_op(KIND_ERASE, 8'h00, 10'd0,    11'd1);
    send_op(KIND_WRITE, 8'h00, 10'd0,    11'd0);
    send_op(KIND_WRITE, 8'hFF, 10'd1023, 11'd1024);
    send_op(KIND_WRITE, 8'hA5, 10'd0,    11'd0);
    send_op(KIND_PEEK,  8'h00, 10'd0,    11'd0);
    send_op(KIND_PEEK,  8'h00, 10'd2,    11'd0);
    send_op(KIND_PEEK,  8'h00, 10'd3,    11'd0);
    send_op(KIND_PEEK,  8'h00, 10'd1023, 11'd0);
    send_op(KIND_READ,  8'h00, 10'd0,    11'd0);
    send_op(KIND_ERASE, 8'h00, 10'd0,    11'd2);
    send_op(KIND_ERASE, 8'h00, 10'd0,    11'd1024);

    // zero capacity acts as one byte
    set_capacity(11'd0);
    send_op(KIND_WRITE, 8'h5A, 10'd0, 11'd0);
    send_op(KIND_WRITE, 8'h3C, 10'd0, 11'd0);
    send_op(KIND_READ,  8'h00, 10'd0, 11'd0);
    send_op(KIND_READ,  8'h00, 10'd0, 11'd0);

    set_capacity(11'd2);
    send_op(KIND_WRITE, 8'h11, 10'd0, 11'd0);
    send_op(KIND_WRITE, 8'h22, 10'd0, 11'd0);
    send_op(KIND_WRITE, 8'h33, 10'd0, 11'd0);
    send_op(KIND_PEEK,  8'h00, 10'd1, 11'd0);
    send_op(KIND_READ,  8'h00, 10'd0, 11'd0);
    send_op(KIND_READ,  8'h00, 10'd0, 11'd0);
    send_op(KIND_READ,  8'h00, 10'd0, 11'd0);

    set_capacity(11'd3);
    run_random(130);
    set_capacity(11'd16);
    run_random(130);

    tx_idle_pct = 69;
    rx_idle_pct <= 32;
    set_capacity(11'd1);
    run_random(60);
    set_capacity(CAP_W'($urandom_range(64, 2)));
    run_random(130);
    set_capacity(11'd1000);
    run_random(80);

    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    // oversized value acts as full depth; burst of writes while output stalls
    set_capacity(11'd2047);
    hold_go <= 1'b1;
    repeat (64)
      send_op(KIND_WRITE, BYTE_W'($urandom_range(255)), 10'd0, 11'd0);
    send_op(KIND_PEEK,  8'h00, 10'd1023, 11'd0);
    send_op(KIND_PEEK,  8'h00, 10'd63,   11'd0);
    send_op(KIND_READ,  8'h00, 10'd0,    11'd0);
    send_op(KIND_WRITE, 8'hC3, 10'd0,    11'd0);
    send_op(KIND_ERASE, 8'h00, 10'd0,    11'd1024);
    send_op(KIND_ERASE, 8'h00, 10'd0,    11'd0);
    send_op(KIND_PEEK,  8'h00, 10'd0,    11'd0);

    set_capacity(11'd7);
    run_random(90);
    set_capacity(11'd1024);
    run_random(90);

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("overwriting_byte_ring_buffer test passed");
    else
      $display("overwriting_byte_ring_buffer test failed");
    $finish;
  end

endmodule
